/* hw/rtl/rmn_pkg.sv */
// Shared types, symbol codes and digit pattern tables for the Roman numeral encoder.
`default_nettype none

package rmn_pkg;

    localparam int VALUE_W  = 14;
    localparam int DIGIT_W  = 4;
    localparam int SYMBOL_W = 3;
    localparam int COUNT_W  = 5;
    localparam int PAT_W    = 16;
    localparam int POS_W    = 2;

    typedef logic [VALUE_W-1:0]  t_value;
    typedef logic [DIGIT_W-1:0]  t_digit;
    typedef logic [SYMBOL_W-1:0] t_symbol;
    typedef logic [PAT_W-1:0]    t_pattern;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [3:0]          t_code;

    // Result symbol codes.
    localparam t_symbol SYM_NONE = 3'd0;
    localparam t_symbol SYM_I    = 3'd1;
    localparam t_symbol SYM_V    = 3'd2;
    localparam t_symbol SYM_X    = 3'd3;
    localparam t_symbol SYM_L    = 3'd4;
    localparam t_symbol SYM_C    = 3'd5;
    localparam t_symbol SYM_D    = 3'd6;
    localparam t_symbol SYM_M    = 3'd7;

    // Nibble codes of a digit pattern, low nibble emitted first.
    localparam t_code CODE_NONE = 4'd0;
    localparam t_code CODE_ONE  = 4'd1;
    localparam t_code CODE_FIVE = 4'd2;
    localparam t_code CODE_TEN  = 4'd3;
    localparam t_code CODE_ERR  = 4'd4;

    // Digit positions, most significant first.
    localparam t_pos POS_THOU = 2'd0;
    localparam t_pos POS_HUND = 2'd1;
    localparam t_pos POS_TENS = 2'd2;
    localparam t_pos POS_UNIT = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SPLIT,
        S_EMIT,
        S_EMPTY
    } t_state;

    // Decimal digits handed from the splitter to the emitter.
    typedef struct packed {
        logic   done;
        t_digit thou;
        t_digit hund;
        t_digit tens;
        t_digit unit;
    } t_digits;

    function automatic t_pattern digit_pattern(input t_digit digit);
        t_pattern pat;
        case (digit)
            4'd1:    pat = {CODE_NONE, CODE_NONE, CODE_NONE, CODE_ONE};
            4'd2:    pat = {CODE_NONE, CODE_NONE, CODE_ONE,  CODE_ONE};
            4'd3:    pat = {CODE_NONE, CODE_ONE,  CODE_ONE,  CODE_ONE};
            4'd4:    pat = {CODE_NONE, CODE_NONE, CODE_FIVE, CODE_ONE};
            4'd5:    pat = {CODE_NONE, CODE_NONE, CODE_NONE, CODE_FIVE};
            4'd6:    pat = {CODE_NONE, CODE_NONE, CODE_ONE,  CODE_FIVE};
            4'd7:    pat = {CODE_NONE, CODE_ONE,  CODE_ONE,  CODE_FIVE};
            4'd8:    pat = {CODE_ONE,  CODE_ONE,  CODE_ONE,  CODE_FIVE};
            4'd9:    pat = {CODE_NONE, CODE_NONE, CODE_TEN,  CODE_ONE};
            default: pat = '0;
        endcase
        return pat;
    endfunction

    // The thousands place only has M; a digit above three becomes one error result.
    function automatic t_pattern pos_pattern(input t_pos pos, input t_digit digit);
        t_pattern pat;
        if (pos == POS_THOU && digit > 4'd3) begin
            pat = {CODE_NONE, CODE_NONE, CODE_NONE, CODE_ERR};
        end else begin
            pat = digit_pattern(digit);
        end
        return pat;
    endfunction

    function automatic t_symbol code_symbol(input t_pos pos, input t_code code);
        t_symbol one;
        t_symbol five;
        t_symbol ten;
        case (pos)
            POS_THOU: begin one = SYM_M; five = SYM_NONE; ten = SYM_NONE; end
            POS_HUND: begin one = SYM_C; five = SYM_D;    ten = SYM_M;    end
            POS_TENS: begin one = SYM_X; five = SYM_L;    ten = SYM_C;    end
            default:  begin one = SYM_I; five = SYM_V;    ten = SYM_X;    end
        endcase
        case (code)
            CODE_ONE:  return one;
            CODE_FIVE: return five;
            CODE_TEN:  return ten;
            default:   return SYM_NONE;
        endcase
    endfunction

    function automatic t_value split_weight(input t_pos pos);
        case (pos)
            POS_THOU: return t_value'(1000);
            POS_HUND: return t_value'(100);
            default:  return t_value'(10);
        endcase
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rmn_if.sv */
// Request channel interfaces for the input value and the output symbols.
`default_nettype none

interface rmn_in_if;
    import rmn_pkg::*;

    logic   valid;
    logic   ready;
    t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rmn_out_if;
    import rmn_pkg::*;

    logic    valid;
    logic    ready;
    t_symbol symbol;
    logic    error;
    logic    last;

    modport source (output valid, output symbol, output error, output last, input ready);
    modport sink   (input valid, input symbol, input error, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rmn_split.sv */
// Iterative decimal digit splitter built on one shared compare and subtract unit.
`default_nettype none

module rmn_split (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire rmn_pkg::t_value i_value,
    output rmn_pkg::t_digits     o_digits
);
    import rmn_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    t_pos                 r_pos;
    t_value               r_rem;
    logic [COUNT_W-1:0]   r_cnt;
    t_digit               r_thou;
    t_digit               r_hund;
    t_digit               r_tens;
    t_digit               r_unit;

    t_value               weight;
    logic                 ge;
    t_value               diff;
    t_digit               digit;

    always_comb begin
        weight = split_weight(r_pos);
        ge     = (r_rem >= weight);
        diff   = r_rem - weight;
        // The thousands count can reach sixteen; only its last decimal digit counts.
        if (r_cnt >= COUNT_W'(10)) begin
            digit = DIGIT_W'(r_cnt - COUNT_W'(10));
        end else begin
            digit = DIGIT_W'(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pos  <= POS_THOU;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_pos  <= POS_THOU;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (ge) begin
                    r_cnt <= r_cnt + COUNT_W'(1);
                end else begin
                    r_cnt <= '0;
                    if (r_pos == POS_TENS) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_pos <= r_pos + POS_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_value;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= diff;
            end else begin
                case (r_pos)
                    POS_THOU: r_thou <= digit;
                    POS_HUND: r_hund <= digit;
                    default: begin
                        r_tens <= digit;
                        r_unit <= DIGIT_W'(r_rem);
                    end
                endcase
            end
        end
    end

    assign o_digits = '{done: r_done, thou: r_thou, hund: r_hund,
                        tens: r_tens, unit: r_unit};

endmodule

`default_nettype wire

/* hw/rtl/roman_numeral_encoder.sv */
// Top level of the Roman numeral encoder: request handling and symbol sequencer.
`default_nettype none

// The block takes one value per request and returns its Roman numeral one symbol
// per output request, thousands first, using the subtractive forms IV, IX, XL,
// XC, CD and CM; the final symbol of a value carries last. A thousands digit above
// three (taken as the value divided by 1000, modulo ten) gives one error result
// with no symbol, and the lower digits follow as usual. A value of zero gives a
// single empty result with last set. The block handles one value at a time and
// holds its input ready low from acceptance until the last symbol has been taken.
// After acceptance a shared compare and subtract unit splits the value into
// decimal digits, one subtraction of 1000, 100 or 10 per cycle, counting
// floor(value / 1000) and then the hundreds and tens digits, and takes the
// remainder as the units digit; the digits are then handed over with a
// registered done strobe. Emission then gives one symbol per output handshake
// and steps from each digit place to the next once its pattern is used up. The
// next value can be accepted in the cycle after the last symbol has been taken.

module roman_numeral_encoder (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rmn_in_if.sink     i_in,
    rmn_out_if.source  o_out
);
    import rmn_pkg::*;

    t_state   r_state;
    t_state   n_state;
    t_pos     r_pos;
    t_pos     n_pos;
    t_pattern r_pat;
    t_pattern n_pat;

    t_digits  digits;
    t_digit   dig [4];
    t_pos     pos_next;
    t_pattern pat_first;
    t_pattern pat_next;
    logic     start;
    logic     lower_zero;
    logic     any_symbol;

    rmn_split u_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_value  (i_in.value),
        .o_digits (digits)
    );

    always_comb begin
        dig[POS_THOU] = digits.thou;
        dig[POS_HUND] = digits.hund;
        dig[POS_TENS] = digits.tens;
        dig[POS_UNIT] = digits.unit;

        pos_next  = r_pos + POS_W'(1);
        pat_first = pos_pattern(POS_THOU, digits.thou);
        pat_next  = pos_pattern(pos_next, dig[pos_next]);

        // Nothing follows in the lower places when their digits are all zero.
        case (r_pos)
            POS_THOU: lower_zero = (digits.hund == '0) && (digits.tens == '0) &&
                                   (digits.unit == '0);
            POS_HUND: lower_zero = (digits.tens == '0) && (digits.unit == '0);
            POS_TENS: lower_zero = (digits.unit == '0);
            default:  lower_zero = 1'b1;
        endcase

        any_symbol = (pat_first != '0) || (digits.hund != '0) ||
                     (digits.tens != '0) || (digits.unit != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= POS_THOU;
            r_pat   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_pat   <= n_pat;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_pat        = r_pat;
        start        = 1'b0;
        i_in.ready   = 1'b0;
        o_out.valid  = 1'b0;
        o_out.symbol = SYM_NONE;
        o_out.error  = 1'b0;
        o_out.last   = 1'b0;

        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    start   = 1'b1;
                    n_state = S_SPLIT;
                end
            end

            S_SPLIT: begin
                if (digits.done) begin
                    n_pos = POS_THOU;
                    n_pat = pat_first;
                    if (any_symbol) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_EMPTY;
                    end
                end
            end

            S_EMIT: begin
                if (r_pat == '0) begin
                    // This place is used up; load the pattern of the next one.
                    n_pos = pos_next;
                    n_pat = pat_next;
                end else begin
                    o_out.valid  = 1'b1;
                    o_out.symbol = code_symbol(r_pos, r_pat[3:0]);
                    o_out.error  = (r_pat[3:0] == CODE_ERR);
                    o_out.last   = (r_pat[PAT_W-1:4] == '0) && lower_zero;
                    if (o_out.ready) begin
                        n_pat = {4'b0, r_pat[PAT_W-1:4]};
                        if (o_out.last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end

            S_EMPTY: begin
                o_out.valid = 1'b1;
                o_out.last  = 1'b1;
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
